>>> rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int unsigned MAX_FIRE = 16;

    localparam logic [19:0] US_PER_SEC = 20'd1000000;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;
    localparam logic [29:0] NSEC_MAX   = 30'd999999999;

    // delay / 1e6 == ((delay >> 6) * US_DIV_RECIP) >> US_DIV_SHIFT for 31-bit delays
    localparam logic [25:0] US_DIV_RECIP = 26'd35184373;
    localparam int unsigned US_DIV_SHIFT = 39;

    typedef enum logic [1:0] {
        MODE_REL  = 2'd0,
        MODE_ABS  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FIRED    = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_SHIFT,
        S_FIRE,
        S_POP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] task_id;
        logic [31:0] time_sec;
        logic [29:0] time_nsec;
        logic [30:0] delay_us;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_task;
        logic        last;
    } out_item_t;

endpackage

>>> rtl/dtq_if.sv
// ----------------------------------------------------------------------------
// dtq_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface dtq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// Deadline-ordered task queue held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   mode, task_id, time_sec, time_nsec, delay_us
//  out_ch   out  status, fired_task, last
//
// One item at a time. An add reads and compares the used entries in order
// until one has a later deadline, then moves the tail up one entry at a time
// (read, then write) and writes the new entry; a relative add first forms the
// deadline (reciprocal divide by 1e6, then the nanosecond carry). A tick reads
// and checks the head; each pop moves the rest down one entry at a time.
// Reset clears the used count and clock at once.
// Output stalls hold the engine; the output register parts the two sides.
module deadline_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic clk,
    input  logic rst_n,
    dtq_if.sink   in_ch,
    dtq_if.source out_ch
);
    import dtq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 32 + 30 + TASK_BITS;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [4:0]    fired_reg, fired_next;
    logic [31:0]   clk_sec_reg, clk_sec_next;
    logic [29:0]   clk_nsec_reg, clk_nsec_next;
    logic [31:0]   key_sec_reg, key_sec_next;
    logic [29:0]   key_nsec_reg, key_nsec_next;
    logic [TASK_BITS-1:0] key_task_reg, key_task_next;
    logic          is_tick_reg, is_tick_next;
    logic          rd_wait_reg, rd_wait_next;
    // relative deadline: quotient, remainder and nanosecond sum, one step a cycle
    logic [30:0]   delay_reg, delay_next;
    logic [11:0]   quo_reg, quo_next;
    logic [19:0]   rem_reg, rem_next;
    logic [30:0]   nsum_reg, nsum_next;
    logic [1:0]    dcnt_reg, dcnt_next;
    out_item_t     out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [29:0]   in_nsec;
    logic [31:0]   rd_sec;
    logic [29:0]   rd_nsec;
    logic [TASK_BITS-1:0] rd_task;
    logic          key_before_rd;
    logic          rd_before_clk;
    logic          fire_due;
    logic [50:0]   recip_prod;
    logic [30:0]   quo_us;
    logic [29:0]   dnsec;
    logic          out_free;

    assign in_nsec = (in_ch.data.time_nsec > NSEC_MAX) ? NSEC_MAX : in_ch.data.time_nsec;
    assign rd_sec  = rd_data[EW-1 -: 32];
    assign rd_nsec = rd_data[TASK_BITS +: 30];
    assign rd_task = rd_data[TASK_BITS-1:0];
    assign key_before_rd = (key_sec_reg != rd_sec) ? (key_sec_reg < rd_sec)
                                                   : (key_nsec_reg < rd_nsec);
    assign rd_before_clk = (rd_sec != clk_sec_reg) ? (rd_sec < clk_sec_reg)
                                                   : (rd_nsec < clk_nsec_reg);
    assign fire_due   = (count_reg != '0) && (fired_reg != 5'(MAX_FIRE)) && rd_before_clk;
    assign recip_prod = {26'd0, delay_reg[30:6]} * {25'd0, US_DIV_RECIP};
    assign quo_us     = {19'd0, quo_reg} * {11'd0, US_PER_SEC};
    assign dnsec      = {10'd0, rem_reg} * {20'd0, NS_PER_US};
    assign out_free   = !out_valid_reg || out_ch.ready;

    assign in_ch.ready  = (state_reg == S_IDLE) && out_free;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            clk_sec_reg   <= '0;
            clk_nsec_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clk_sec_reg   <= clk_sec_next;
            clk_nsec_reg  <= clk_nsec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        fired_reg    <= fired_next;
        key_sec_reg  <= key_sec_next;
        key_nsec_reg <= key_nsec_next;
        key_task_reg <= key_task_next;
        is_tick_reg  <= is_tick_next;
        rd_wait_reg  <= rd_wait_next;
        delay_reg    <= delay_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        nsum_reg     <= nsum_next;
        dcnt_reg     <= dcnt_next;
        out_reg      <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (mode_t'(in_ch.data.mode))
                        MODE_REL:  state_next = S_DIV;
                        MODE_ABS:  state_next = S_SCAN;
                        MODE_TICK: state_next = S_FIRE;
                        MODE_NONE: state_next = S_OUT;
                    endcase
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == 2'd3)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    state_next = S_OUT;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_SHIFT;
                end
                else if (rd_wait_reg && key_before_rd)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_FIRE:
            begin
                if (rd_wait_reg)
                begin
                    if (fire_due && (fired_reg == '0 || out_free))
                    begin
                        state_next = S_POP;
                    end
                    else if (!fire_due)
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_POP:
            begin
                if (idx_reg > count_reg)
                begin
                    state_next = S_FIRE;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fired_next     = fired_reg;
        clk_sec_next   = clk_sec_reg;
        clk_nsec_next  = clk_nsec_reg;
        key_sec_next   = key_sec_reg;
        key_nsec_next  = key_nsec_reg;
        key_task_next  = key_task_reg;
        is_tick_next   = is_tick_reg;
        rd_wait_next   = 1'b0;
        delay_next     = delay_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        nsum_next      = nsum_reg;
        dcnt_next      = dcnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_data        = {key_sec_reg, key_nsec_reg, key_task_reg};
        wr_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                fired_next = '0;
                if (in_ch.valid && in_ch.ready)
                begin
                    key_sec_next  = in_ch.data.time_sec;
                    key_nsec_next = in_nsec;
                    key_task_next = in_ch.data.task_id[TASK_BITS-1:0];
                    is_tick_next  = (in_ch.data.mode == MODE_TICK) ||
                                    (in_ch.data.mode == MODE_NONE);
                    delay_next    = in_ch.data.delay_us;
                    dcnt_next     = '0;
                    if (in_ch.data.mode == MODE_TICK)
                    begin
                        clk_sec_next  = in_ch.data.time_sec;
                        clk_nsec_next = in_nsec;
                    end
                end
            end
            S_DIV:
            begin
                dcnt_next = dcnt_reg + 2'd1;
                unique case (dcnt_reg)
                    2'd0: quo_next = recip_prod[US_DIV_SHIFT +: 12];
                    2'd1:
                    begin
                        rem_next     = 20'(delay_reg - quo_us);
                        key_sec_next = clk_sec_reg + {20'd0, quo_reg};
                    end
                    2'd2: nsum_next = {1'b0, clk_nsec_reg} + {1'b0, dnsec};
                    2'd3:
                    begin
                        // one carry is enough: both terms are below one second
                        if (nsum_reg >= {1'b0, NS_PER_SEC})
                        begin
                            key_sec_next  = key_sec_reg + 32'd1;
                            key_nsec_next = 30'(nsum_reg - {1'b0, NS_PER_SEC});
                        end
                        else
                        begin
                            key_nsec_next = nsum_reg[29:0];
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    out_next = '{status: ST_FULL, fired_task: '0, last: 1'b1};
                end
                else if (idx_reg == count_reg)
                begin
                    pos_next = idx_reg;
                end
                else if (rd_wait_reg)
                begin
                    if (key_before_rd)
                    begin
                        pos_next = idx_reg;
                        idx_next = count_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    rd_addr      = idx_reg[AW-1:0];
                    rd_wait_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // move entry idx-1 up to idx, then place the new one at pos
                if (idx_reg == pos_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    out_next = '{status: ST_ACCEPTED, fired_task: '0, last: 1'b1};
                end
                else if (rd_wait_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_reg - CW'(1);
                end
                else
                begin
                    rd_addr      = AW'(idx_reg - CW'(1));
                    rd_wait_next = 1'b1;
                end
            end
            S_FIRE:
            begin
                // a fired task is held in key_task until the next head check
                // tells whether it is the last one
                rd_addr = '0;
                if (!rd_wait_reg)
                begin
                    rd_wait_next = 1'b1;
                end
                else if (fire_due)
                begin
                    if (fired_reg == '0 || out_free)
                    begin
                        if (fired_reg != '0)
                        begin
                            out_valid_next = 1'b1;
                            out_next = '{status: ST_FIRED, fired_task: 16'(key_task_reg),
                                         last: 1'b0};
                        end
                        key_task_next = rd_task;
                        fired_next    = fired_reg + 5'd1;
                        count_next    = count_reg - CW'(1);
                        idx_next      = CW'(1);
                    end
                    else
                    begin
                        rd_wait_next = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                if (idx_reg <= count_reg)
                begin
                    if (rd_wait_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(idx_reg - CW'(1));
                        wr_data  = rd_data;
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        rd_addr      = idx_reg[AW-1:0];
                        rd_wait_next = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (fired_reg != '0)
                    begin
                        out_next = '{status: ST_FIRED, fired_task: 16'(key_task_reg),
                                     last: 1'b1};
                    end
                    else if (is_tick_reg)
                    begin
                        out_next = '{status: ST_NONE, fired_task: '0, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (fired_reg != '0))
        else $error("pop without fire");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
        else $error("item accepted but engine idle");
endmodule

>>> test/deadline_timer_queue_core_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core_tb
// Drives adds and ticks into the deadline timer queue and checks every
// result against a behavioral queue model kept in the testbench.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int DEPTH = 16;
    localparam int LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dtq_if #(.T(in_item_t))  in_ch ();
    dtq_if #(.T(out_item_t)) out_ch ();

    deadline_timer_queue_core #(.QUEUE_DEPTH(DEPTH), .TASK_BITS(16)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #10 clk = ~clk;

    // queue model
    logic [31:0] q_sec [$];
    logic [29:0] q_nsec [$];
    logic [15:0] q_task [$];
    logic [31:0] now_sec;
    logic [29:0] now_nsec;

    out_item_t pending [$];
    int errors;
    int sent;
    int fired_seen;
    int cycles;
    int send_idle;
    int recv_stall;

    function automatic bit is_before(logic [31:0] as, logic [29:0] an,
                                     logic [31:0] bs, logic [29:0] bn);
        if (as != bs)
            return as < bs;
        return an < bn;
    endfunction

    function automatic logic [29:0] sat_nsec(logic [29:0] v);
        return (v > NSEC_MAX) ? NSEC_MAX : v;
    endfunction

    function automatic out_item_t mk(status_t s, logic [15:0] t, logic l);
        out_item_t r;
        r.status = s;
        r.fired_task = t;
        r.last = l;
        return r;
    endfunction

    function automatic void enqueue_deadline(logic [31:0] s, logic [29:0] ns,
                                             logic [15:0] t);
        int pos;
        pos = q_sec.size();
        if (q_sec.size() >= DEPTH)
        begin
            pending.push_back(mk(ST_FULL, 16'd0, 1'b1));
            return;
        end
        for (int i = 0; i < q_sec.size(); i++)
        begin
            if (is_before(s, ns, q_sec[i], q_nsec[i]))
            begin
                pos = i;
                break;
            end
        end
        q_sec.insert(pos, s);
        q_nsec.insert(pos, ns);
        q_task.insert(pos, t);
        pending.push_back(mk(ST_ACCEPTED, 16'd0, 1'b1));
    endfunction

    function automatic void predict_timer(in_item_t it);
        logic [31:0] ds;
        logic [31:0] dn;
        logic [31:0] ws;
        logic [31:0] wn;
        int n;
        n = 0;
        case (mode_t'(it.mode))
            MODE_REL:
            begin
                ds = it.delay_us / 32'd1000000;
                dn = (it.delay_us % 32'd1000000) * 32'd1000;
                ws = now_sec + ds;
                wn = now_nsec + dn;
                if (wn >= 32'd1000000000)
                begin
                    ws = ws + 32'd1;
                    wn = wn - 32'd1000000000;
                end
                enqueue_deadline(ws, wn[29:0], it.task_id);
            end
            MODE_ABS:
                enqueue_deadline(it.time_sec, sat_nsec(it.time_nsec), it.task_id);
            MODE_TICK:
            begin
                now_sec = it.time_sec;
                now_nsec = sat_nsec(it.time_nsec);
                while (n < MAX_FIRE && q_sec.size() > 0
                       && is_before(q_sec[0], q_nsec[0], now_sec, now_nsec))
                begin
                    pending.push_back(mk(ST_FIRED, q_task[0], 1'b0));
                    void'(q_sec.pop_front());
                    void'(q_nsec.pop_front());
                    void'(q_task.pop_front());
                    n++;
                end
                if (n > 0)
                    pending[pending.size() - 1].last = 1'b1;
                else
                    pending.push_back(mk(ST_NONE, 16'd0, 1'b1));
            end
            default:
                pending.push_back(mk(ST_NONE, 16'd0, 1'b1));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // valid stays up after the accept edge until the next call or a drain
    task automatic send_item(in_item_t it);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_timer(it);
        sent++;
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(mode_t m, logic [15:0] t, logic [31:0] s,
                                           logic [29:0] ns, logic [30:0] d);
        in_item_t it;
        it.mode = m;
        it.task_id = t;
        it.time_sec = s;
        it.time_nsec = ns;
        it.delay_us = d;
        return it;
    endfunction

    function automatic in_item_t random_item(int tick_pct);
        in_item_t it;
        it.task_id = 16'($urandom);
        it.time_sec = ($urandom_range(3) == 0) ? $urandom : now_sec + $urandom_range(3);
        it.time_nsec = ($urandom_range(15) == 0) ? 30'($urandom) : 30'($urandom_range(999999999));
        it.delay_us = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(3000000));
        if ($urandom_range(99) < tick_pct)
            it.mode = MODE_TICK;
        else if ($urandom_range(40) == 0)
            it.mode = MODE_NONE;
        else
            it.mode = $urandom_range(1) ? MODE_ABS : MODE_REL;
        return it;
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d", got.status));
            else
            begin
                want = pending.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.fired_task !== want.fired_task)
                    report_mismatch($sformatf("task %h want %h", got.fired_task,
                                              want.fired_task));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
                if (got.status == ST_FIRED)
                    fired_seen++;
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        // min/max fields, nsec saturation, unused mode
        send_item(make_item(MODE_TICK, 16'h0000, 32'd0, 30'd0, 31'd0));
        send_item(make_item(MODE_ABS, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF, 31'h7FFFFFFF));
        send_item(make_item(MODE_ABS, 16'h0001, 32'd0, 30'd0, 31'd0));
        send_item(make_item(MODE_REL, 16'h0002, 32'd0, 30'd0, 31'd0));
        send_item(make_item(MODE_REL, 16'h0003, 32'hFFFFFFFF, 30'h3FFFFFFF, 31'h7FFFFFFF));
        send_item(make_item(MODE_NONE, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF, 31'h7FFFFFFF));
        send_item(make_item(MODE_TICK, 16'd0, 32'd0, 30'd1, 31'd0));
        // seconds wrap on relative add near top of time
        send_item(make_item(MODE_TICK, 16'd0, 32'hFFFFFFFF, 30'd999999999, 31'd0));
        send_item(make_item(MODE_REL, 16'h00AA, 32'd0, 30'd0, 31'd1));
        send_item(make_item(MODE_REL, 16'h00AB, 32'd0, 30'd0, 31'd2500000));
        send_item(make_item(MODE_TICK, 16'd0, 32'd5, 30'd0, 31'd0));
        send_item(make_item(MODE_TICK, 16'd0, 32'hFFFFFFFF, 30'h3FFFFFFF, 31'd0));
    endtask

    task automatic test_full_and_burst();
        // fill past depth with equal deadlines, then fire in insertion order
        send_item(make_item(MODE_TICK, 16'd0, 32'd0, 30'd0, 31'd0));
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(make_item(MODE_ABS, 16'(16'h100 + i), 32'd7, 30'd500, 31'd0));
        send_item(make_item(MODE_TICK, 16'd0, 32'd7, 30'd500, 31'd0));
        send_item(make_item(MODE_TICK, 16'd0, 32'd7, 30'd501, 31'd0));
        send_item(make_item(MODE_TICK, 16'd0, 32'd7, 30'd502, 31'd0));
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < count; i++)
        begin
            send_item(random_item(30));
            if (i == count / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        now_sec = '0;
        now_nsec = '0;
        errors = 0;
        sent = 0;
        fired_seen = 0;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_and_burst();
        test_random(72, 0, 0);
        test_random(72, 78, 0);
        test_random(72, 0, 78);
        test_random(72, 12, 12);
        recv_stall = 0;
        wait_drained();
        repeat (200) @(posedge clk);
        $display("covered %0d items: adds, full queue, ticks with %0d fired tasks,",
                 sent, fired_seen);
        $display("nsec saturation, seconds wrap, unused mode, idle and stall phases");
        if (errors == 0 && pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
rtl/dtq_pkg.sv
rtl/dtq_if.sv
rtl/deadline_timer_queue_core.sv
test/deadline_timer_queue_core_tb.sv
